// ----- rtl/rfab_pkg.sv -----
// Shared types, constants and helpers for the rectangle fill and alpha blend block.
// Used by every module in rtl/ except rfab_fifo; depends on nothing.
package rfab_pkg;

	localparam int DEF_FRAME_WIDTH = 256;
	localparam int DEF_FRAME_HEIGHT = 256;
	localparam int CNT_W = 9;
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_FILL = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef enum logic [1:0] {
		K_CLEAR = 2'd0,
		K_FILL = 2'd1,
		K_READ = 2'd2,
		K_NOP = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} color_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] x;
		logic [7:0] y;
		logic [CNT_W-1:0] cols;
		logic [CNT_W-1:0] rows;
		color_t color;
	} cmd_t;

	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ----- rtl/rfab_fifo.sv -----
// Small register queue used between the front and back parts and for results.
// Generic payload width; depends on nothing.
module rfab_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/rfab_front.sv -----
// Front part: classifies an item and clips its rectangle to the frame.
// Depends on rfab_pkg.
module rfab_front #(
	parameter int FRAME_WIDTH = 256,
	parameter int FRAME_HEIGHT = 256
) (
	input  logic          [1:0] op,
	input  logic          [7:0] x_left,
	input  logic          [7:0] y_top,
	input  logic          [8:0] rect_width,
	input  logic          [8:0] rect_height,
	input  logic          [7:0] red,
	input  logic          [7:0] green,
	input  logic          [7:0] blue,
	input  logic          [7:0] alpha,
	output rfab_pkg::cmd_t      cmd
);

	import rfab_pkg::*;

	localparam int XW = ($clog2(FRAME_WIDTH + 1) > 10) ? $clog2(FRAME_WIDTH + 1) : 10;
	localparam int YW = ($clog2(FRAME_HEIGHT + 1) > 10) ? $clog2(FRAME_HEIGHT + 1) : 10;
	localparam logic [XW-1:0] W_LIM = XW'(FRAME_WIDTH);
	localparam logic [YW-1:0] H_LIM = YW'(FRAME_HEIGHT);

	logic in_frame;
	logic [XW-1:0] x_ext;
	logic [YW-1:0] y_ext;
	logic [XW-1:0] x_end;
	logic [YW-1:0] y_end;
	logic [XW-1:0] x_cnt;
	logic [YW-1:0] y_cnt;

	always_comb begin
		x_ext = XW'(x_left);
		y_ext = YW'(y_top);
		in_frame = (x_ext < W_LIM) && (y_ext < H_LIM);
		x_end = x_ext + XW'(rect_width);
		y_end = y_ext + YW'(rect_height);
		if (x_end > W_LIM) begin
			x_end = W_LIM;
		end
		if (y_end > H_LIM) begin
			y_end = H_LIM;
		end
		x_cnt = x_end - x_ext;
		y_cnt = y_end - y_ext;

		cmd.x = x_left;
		cmd.y = y_top;
		cmd.cols = x_cnt[CNT_W-1:0];
		cmd.rows = y_cnt[CNT_W-1:0];
		cmd.color.red = red;
		cmd.color.green = green;
		cmd.color.blue = blue;
		cmd.color.alpha = alpha;
		case (op)
			OP_CLEAR: begin
				cmd.kind = K_CLEAR;
			end
			OP_FILL: begin
				cmd.kind = (in_frame && rect_width != '0 && rect_height != '0) ? K_FILL : K_NOP;
			end
			OP_READ: begin
				cmd.kind = in_frame ? K_READ : K_NOP;
			end
			default: begin
				cmd.kind = K_NOP;
			end
		endcase
	end

endmodule

// ----- rtl/rfab_back.sv -----
// Back part: sequencer over the frame store with a read-modify-write blend pipeline.
// Holds the frame memory; depends on rfab_pkg.
module rfab_back #(
	parameter int FRAME_WIDTH = 256,
	parameter int FRAME_HEIGHT = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_empty,
	input  rfab_pkg::cmd_t       cmd_data,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output rfab_pkg::color_t     res_pix,
	output logic                 init_busy
);

	import rfab_pkg::*;

	localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW = (PIX > 1) ? $clog2(PIX) : 1;
	localparam int MW = AW + 9;
	localparam logic [AW-1:0] LAST_ADDR = AW'(PIX - 1);
	localparam logic [AW-1:0] ROW_STEP = AW'(FRAME_WIDTH);

	typedef enum logic [7:0] {
		ST_INIT = 8'b00000001,
		ST_IDLE = 8'b00000010,
		ST_CLEAR = 8'b00000100,
		ST_FILL = 8'b00001000,
		ST_READ = 8'b00010000,
		ST_RDWAIT = 8'b00100000,
		ST_DRAIN = 8'b01000000,
		ST_RESP = 8'b10000000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] base_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	color_t res_pix_q;

	logic [31:0] mem_q [PIX];
	color_t rdata_s1;
	logic v_s1;
	logic [AW-1:0] addr_s1;
	logic v_s2;
	logic [AW-1:0] addr_s2;
	logic [15:0] sum_r_s2;
	logic [15:0] sum_g_s2;
	logic [15:0] sum_b_s2;

	logic [MW-1:0] start_full;
	logic [AW-1:0] start_addr;
	logic we;
	logic [AW-1:0] wa;
	logic [31:0] wd;
	color_t blend;
	logic [7:0] inv_a;

	assign start_full = MW'(cmd_data.y) * MW'(FRAME_WIDTH) + MW'(cmd_data.x);
	assign start_addr = start_full[AW-1:0];
	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;
	assign res_push = (state_q == ST_RESP) && !res_full;
	assign res_pix = res_pix_q;
	assign init_busy = (state_q == ST_INIT);
	assign inv_a = 8'd255 - cmd_q.color.alpha;

	always_comb begin
		blend.red = div255(sum_r_s2);
		blend.green = div255(sum_g_s2);
		blend.blue = div255(sum_b_s2);
		blend.alpha = cmd_q.color.alpha;
		we = v_s2 || (state_q == ST_CLEAR) || (state_q == ST_INIT);
		wa = v_s2 ? addr_s2 : addr_q;
		if (v_s2) begin
			wd = blend;
		end else if (state_q == ST_INIT) begin
			wd = '0;
		end else begin
			wd = cmd_q.color;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rdata_s1 <= mem_q[addr_q];
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		addr_s2 <= addr_s1;
		sum_r_s2 <= 16'(rdata_s1.red) * 16'(inv_a)
			+ 16'(cmd_q.color.red) * 16'(cmd_q.color.alpha);
		sum_g_s2 <= 16'(rdata_s1.green) * 16'(inv_a)
			+ 16'(cmd_q.color.green) * 16'(cmd_q.color.alpha);
		sum_b_s2 <= 16'(rdata_s1.blue) * 16'(inv_a)
			+ 16'(cmd_q.color.blue) * 16'(cmd_q.color.alpha);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_FILL);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			addr_q <= '0;
			base_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!cmd_empty) begin
						col_q <= '0;
						row_q <= '0;
						base_q <= start_addr;
						case (cmd_data.kind)
							K_CLEAR: begin
								addr_q <= '0;
								state_q <= ST_CLEAR;
							end
							K_FILL: begin
								addr_q <= start_addr;
								state_q <= ST_FILL;
							end
							K_READ: begin
								addr_q <= start_addr;
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_RESP;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_FILL: begin
					if (col_q == cmd_q.cols - 1'b1) begin
						col_q <= '0;
						if (row_q == cmd_q.rows - 1'b1) begin
							state_q <= ST_DRAIN;
						end else begin
							row_q <= row_q + 1'b1;
							base_q <= base_q + ROW_STEP;
							addr_q <= base_q + ROW_STEP;
						end
					end else begin
						col_q <= col_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_RDWAIT;
				end
				ST_RDWAIT: begin
					state_q <= ST_RESP;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_data;
			res_pix_q <= '0;
		end else if (state_q == ST_RDWAIT) begin
			res_pix_q <= rdata_s1;
		end
	end

endmodule

// ----- rtl/rect_fill_alpha_blend.sv -----
// Read item: the back part steps through the READ, RDWAIT and RESP states, then pushes the pixel.
// Clear item: FRAME_WIDTH*FRAME_HEIGHT pixels, one pixel written per cycle.
// Fill item: clipped width * height pixels, one read-modify-write per cycle.
// Other items go straight from IDLE to RESP; items are carried out one at a time by the back part.
// After reset the frame memory is cleared one pixel per cycle while full stays high;
// the queues reset empty.
module rect_fill_alpha_blend #(
	parameter int FRAME_WIDTH = rfab_pkg::DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = rfab_pkg::DEF_FRAME_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] op,
	input  logic [7:0] x_left,
	input  logic [7:0] y_top,
	input  logic [8:0] rect_width,
	input  logic [8:0] rect_height,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	output logic       empty,
	input  logic       pop,
	output logic       done_res,
	output logic [7:0] pix_red,
	output logic [7:0] pix_green,
	output logic [7:0] pix_blue,
	output logic [7:0] pix_alpha
);

	import rfab_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(color_t);

	cmd_t front_cmd;
	cmd_t back_cmd;
	logic [CMD_W-1:0] cmdq_rdata;
	logic cmdq_full;
	logic cmdq_empty;
	logic cmd_pop;
	logic init_busy;
	logic res_push;
	logic resq_full;
	color_t res_pix;
	color_t out_pix;
	logic [RES_W-1:0] resq_rdata;

	assign full = cmdq_full || init_busy;
	assign back_cmd = cmd_t'(cmdq_rdata);
	assign out_pix = color_t'(resq_rdata);
	assign done_res = 1'b1;
	assign pix_red = out_pix.red;
	assign pix_green = out_pix.green;
	assign pix_blue = out_pix.blue;
	assign pix_alpha = out_pix.alpha;

	rfab_front #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_front (
		.op(op),
		.x_left(x_left),
		.y_top(y_top),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.cmd(front_cmd)
	);

	rfab_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push && !full),
		.wdata(front_cmd),
		.full(cmdq_full),
		.pop(cmd_pop),
		.rdata(cmdq_rdata),
		.empty(cmdq_empty)
	);

	rfab_back #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(cmdq_empty),
		.cmd_data(back_cmd),
		.cmd_pop(cmd_pop),
		.res_full(resq_full),
		.res_push(res_push),
		.res_pix(res_pix),
		.init_busy(init_busy)
	);

	rfab_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RESQ_DEPTH)
	) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_pix),
		.full(resq_full),
		.pop(pop),
		.rdata(resq_rdata),
		.empty(empty)
	);

endmodule
